// ===== sv/assert_macros.svh =====
// assertion helpers for the port-level checker revq15_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/revq15_pkg.sv =====
`default_nettype none

package revq15_pkg;

  // delay line geometry: every line holds 2**LINE_AW words
  localparam int LINE_AW = 12;
  localparam int COMB_AW = LINE_AW + 2;
  localparam int DIFF_AW = LINE_AW + 1;

  // fixed diffuser delays in samples
  localparam int DIFF_ONE_DELAY = 240;
  localparam int DIFF_TWO_DELAY = 590;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  // register reset values
  localparam logic signed [15:0] GAIN_RST = 16'sd27525;
  localparam logic [14:0]        WET_RST  = 15'd16384;
  localparam logic [11:0]        DLY_A_RST = 12'd1425;
  localparam logic [11:0]        DLY_B_RST = 12'd1780;
  localparam logic [11:0]        DLY_C_RST = 12'd1972;
  localparam logic [11:0]        DLY_D_RST = 12'd2097;

  // output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW = $clog2(OUTQ_DEPTH);

  typedef enum logic [CFG_AW-1:0] {
    REG_ENABLE  = 3'd0,
    REG_GAIN    = 3'd1,
    REG_WET     = 3'd2,
    REG_DELAY_A = 3'd3,
    REG_DELAY_B = 3'd4,
    REG_DELAY_C = 3'd5,
    REG_DELAY_D = 3'd6
  } cfg_reg_t;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    logic    vld;
    sample_t data;
  } push_t;

endpackage

`default_nettype wire

// ===== sv/comb_allpass_reverb_q15.sv =====
// latency: with reverb on, out_valid rises once the request has passed the issue stage, comb
//   stages s1 and s2, stages t1 to t4 and the result queue; with reverb off the request goes
//   straight into the result queue and out_valid rises at the edge that takes it
// throughput: reverb on, a new sample waits for the last one's four comb reads through the
//   single read port of the comb line memory; off, one per cycle while the queue has room
// reset: synchronous active-low rst_n clears control and restores register defaults;
`default_nettype none

module comb_allpass_reverb_q15 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [15:0]                in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                out_sample,
  input  logic                              cfg_we,
  input  logic [revq15_pkg::CFG_AW-1:0]     cfg_index,
  input  logic [revq15_pkg::CFG_DW-1:0]     cfg_data
);

  // delay lines are not swept: a lap flag and the write pointer make unwritten words read zero
  localparam int AW = revq15_pkg::LINE_AW;

  // configuration registers
  logic                 en_r;
  logic signed [15:0]   gain_r;
  logic [14:0]          wet_mix_r;
  logic [11:0]          delay_r [4];

  // request bookkeeping
  logic [revq15_pkg::OUTQ_AW:0] pend_r;
  logic [revq15_pkg::OUTQ_AW:0] pend_nxt;
  logic                         in_acc;
  logic                         out_acc;
  logic                         credit_ok;
  logic                         iss_free;

  // issue stage and line pointer
  logic                 iss_vld_r;
  logic [1:0]           iss_k_r;
  revq15_pkg::sample_t  iss_x_r;
  logic [AW-1:0]        ptr_r;
  logic                 lap_r;
  logic                 iss_last;
  logic [AW-1:0]        comb_dly;
  logic [AW-1:0]        comb_idx;
  logic                 comb_ok;

  // comb pipeline
  logic                 s1_vld_r;
  logic [1:0]           s1_k_r;
  revq15_pkg::sample_t  s1_x_r;
  logic [AW-1:0]        s1_ptr_r;
  logic                 s1_lap_r;
  logic                 s1_ok_r;
  revq15_pkg::sample_t  s1_y;

  logic                 s2_vld_r;
  logic [1:0]           s2_k_r;
  revq15_pkg::sample_t  s2_x_r;
  logic [AW-1:0]        s2_ptr_r;
  logic                 s2_lap_r;
  revq15_pkg::sample_t  s2_y_r;
  logic signed [31:0]   s2_prod;
  revq15_pkg::sample_t  acc_r;
  revq15_pkg::sample_t  s2_sum;

  logic                 s3_vld_r;
  logic [1:0]           s3_k_r;
  revq15_pkg::sample_t  s3_x_r;
  logic [AW-1:0]        s3_ptr_r;
  logic signed [31:0]   s3_prod_r;
  revq15_pkg::sample_t  s3_w;

  // comb memory ports
  logic [revq15_pkg::COMB_AW-1:0] comb_raddr;
  logic [15:0]                    comb_rdata;

  // diffuser and mix pipeline
  logic                 t1_vld_r;
  revq15_pkg::sample_t  t1_x_r;
  logic [AW-1:0]        t1_ptr_r;
  logic                 t1_lap_r;
  revq15_pkg::sample_t  t1_wet_r;
  revq15_pkg::sample_t  t1_out;

  logic                 t2_vld_r;
  revq15_pkg::sample_t  t2_x_r;
  logic [AW-1:0]        t2_ptr_r;
  revq15_pkg::sample_t  t2_v1_r;
  revq15_pkg::sample_t  t2_out;

  logic                 t3_vld_r;
  revq15_pkg::sample_t  t3_x_r;
  revq15_pkg::sample_t  t3_y_r;
  logic signed [16:0]   t3_diff;
  logic signed [32:0]   t3_prod;

  logic                 t4_vld_r;
  revq15_pkg::sample_t  t4_x_r;
  logic signed [32:0]   t4_prod_r;
  logic signed [32:0]   t4_sum;

  // diffuser memory ports
  logic [AW-1:0]                  diff_idx;
  logic                           diff_ok;
  logic                           diff_ok_r;
  logic [revq15_pkg::DIFF_AW-1:0] diff_raddr;
  logic [15:0]                    diff_rdata;
  revq15_pkg::sample_t            diff_v;
  logic                           diff_we;
  logic [revq15_pkg::DIFF_AW-1:0] diff_waddr;
  revq15_pkg::sample_t            diff_wdata;

  revq15_pkg::push_t    push;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= 1'b0;
      gain_r     <= revq15_pkg::GAIN_RST;
      wet_mix_r  <= revq15_pkg::WET_RST;
      delay_r[0] <= revq15_pkg::DLY_A_RST;
      delay_r[1] <= revq15_pkg::DLY_B_RST;
      delay_r[2] <= revq15_pkg::DLY_C_RST;
      delay_r[3] <= revq15_pkg::DLY_D_RST;
    end else if (cfg_we) begin
      unique case (revq15_pkg::cfg_reg_t'(cfg_index))
        revq15_pkg::REG_ENABLE:  en_r       <= cfg_data[0];
        revq15_pkg::REG_GAIN:    gain_r     <= cfg_data;
        revq15_pkg::REG_WET:     wet_mix_r  <= cfg_data[14:0];
        revq15_pkg::REG_DELAY_A: delay_r[0] <= cfg_data[11:0];
        revq15_pkg::REG_DELAY_B: delay_r[1] <= cfg_data[11:0];
        revq15_pkg::REG_DELAY_C: delay_r[2] <= cfg_data[11:0];
        revq15_pkg::REG_DELAY_D: delay_r[3] <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // input handshake: a queue slot for every request in flight
  assign credit_ok = (pend_r < (revq15_pkg::OUTQ_AW + 1)'(revq15_pkg::OUTQ_DEPTH));
  assign iss_free  = !iss_vld_r || (iss_k_r == 2'd3);
  assign in_stall  = !(credit_ok && (!en_r || iss_free));
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  // issue control, pointer and lap flag
  assign iss_last = iss_vld_r && (iss_k_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      iss_vld_r <= 1'b0;
      ptr_r     <= '0;
      lap_r     <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (in_acc && en_r) begin
        iss_vld_r <= 1'b1;
      end else if (iss_last) begin
        iss_vld_r <= 1'b0;
      end
      if (iss_last) begin
        ptr_r <= ptr_r + 1'b1;
        if (ptr_r == '1) begin
          lap_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && en_r) begin
      iss_k_r <= 2'd0;
      iss_x_r <= in_sample;
    end else if (iss_vld_r) begin
      iss_k_r <= iss_k_r + 1'b1;
    end
  end

  // comb tap address, one comb per cycle
  assign comb_dly   = AW'(delay_r[iss_k_r]);
  assign comb_idx   = ptr_r - comb_dly;
  assign comb_ok    = lap_r || (comb_idx < ptr_r);
  assign comb_raddr = {iss_k_r, comb_idx};

  // comb output: tap plus input
  assign s1_y = (s1_ok_r ? revq15_pkg::sample_t'(comb_rdata) : 16'sd0) + s1_x_r;

  // feedback product and running sum of comb outputs
  assign s2_prod = gain_r * s2_y_r;
  assign s2_sum  = acc_r + s2_y_r;

  // value written back to the comb line
  assign s3_w = s3_x_r + revq15_pkg::sample_t'(s3_prod_r[30:15]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= iss_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      t1_vld_r <= s2_vld_r && (s2_k_r == 2'd3);
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_k_r   <= iss_k_r;
    s1_x_r   <= iss_x_r;
    s1_ptr_r <= ptr_r;
    s1_lap_r <= lap_r;
    s1_ok_r  <= comb_ok;

    s2_k_r   <= s1_k_r;
    s2_x_r   <= s1_x_r;
    s2_ptr_r <= s1_ptr_r;
    s2_lap_r <= s1_lap_r;
    s2_y_r   <= s1_y;

    if (s2_vld_r) begin
      acc_r <= (s2_k_r == 2'd0) ? s2_y_r : s2_sum;
    end

    s3_k_r    <= s2_k_r;
    s3_x_r    <= s2_x_r;
    s3_ptr_r  <= s2_ptr_r;
    s3_prod_r <= s2_prod;

    // quarter of the wrapped comb sum
    t1_x_r   <= s2_x_r;
    t1_ptr_r <= s2_ptr_r;
    t1_lap_r <= s2_lap_r;
    t1_wet_r <= s2_sum >>> 2;

    t2_x_r   <= t1_x_r;
    t2_ptr_r <= t1_ptr_r;
    t2_v1_r  <= t1_out;

    t3_x_r <= t2_x_r;
    t3_y_r <= t2_out;

    t4_x_r    <= t3_x_r;
    t4_prod_r <= t3_prod;

    diff_ok_r <= diff_ok;
  end

  // diffuser reads: the first line is addressed from s2 for t1, the second line from t1 for t2
  always_comb begin
    if (t1_vld_r) begin
      diff_idx   = t1_ptr_r - AW'(revq15_pkg::DIFF_TWO_DELAY);
      diff_ok    = t1_lap_r || (diff_idx < t1_ptr_r);
      diff_raddr = {1'b1, diff_idx};
    end else begin
      diff_idx   = s2_ptr_r - AW'(revq15_pkg::DIFF_ONE_DELAY);
      diff_ok    = s2_lap_r || (diff_idx < s2_ptr_r);
      diff_raddr = {1'b0, diff_idx};
    end
  end

  assign diff_v = diff_ok_r ? revq15_pkg::sample_t'(diff_rdata) : 16'sd0;
  assign t1_out = diff_v - t1_wet_r;
  assign t2_out = diff_v - t2_v1_r;

  // diffuser write-back: stage input into its own line
  always_comb begin
    diff_we = t1_vld_r || t2_vld_r;
    if (t1_vld_r) begin
      diff_waddr = {1'b0, t1_ptr_r};
      diff_wdata = t1_wet_r;
    end else begin
      diff_waddr = {1'b1, t2_ptr_r};
      diff_wdata = t2_v1_r;
    end
  end

  // wet/dry mix as dry + wet_mix * (wet - dry)
  assign t3_diff = {t3_y_r[15], t3_y_r} - {t3_x_r[15], t3_x_r};
  assign t3_prod = $signed({1'b0, wet_mix_r}) * t3_diff;
  assign t4_sum  = $signed({{2{t4_x_r[15]}}, t4_x_r, 15'd0}) + t4_prod_r;

  // result into the queue, straight from the input when bypassed
  always_comb begin
    if (t4_vld_r) begin
      push.vld  = 1'b1;
      push.data = revq15_pkg::sample_t'(t4_sum[30:15]);
    end else begin
      push.vld  = in_acc && !en_r;
      push.data = in_sample;
    end
  end

  revq15_ram #(
    .AW (revq15_pkg::COMB_AW),
    .DW (16)
  ) u_comb_ram (
    .clk   (clk),
    .we    (s3_vld_r),
    .waddr ({s3_k_r, s3_ptr_r}),
    .wdata (s3_w),
    .raddr (comb_raddr),
    .rdata (comb_rdata)
  );

  revq15_ram #(
    .AW (revq15_pkg::DIFF_AW),
    .DW (16)
  ) u_diff_ram (
    .clk   (clk),
    .we    (diff_we),
    .waddr (diff_waddr),
    .wdata (diff_wdata),
    .raddr (diff_raddr),
    .rdata (diff_rdata)
  );

  revq15_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

endmodule

`default_nettype wire

// ===== sv/revq15_ram.sv =====
`default_nettype none

// simple dual-port memory, one write and one registered read per cycle
module revq15_ram #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/revq15_outq.sv =====
`default_nettype none

// small result queue between the datapath and the output channel
module revq15_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  revq15_pkg::push_t    push,
  output logic                 out_valid,
  input  logic                 out_stall,
  output revq15_pkg::sample_t  out_sample
);

  revq15_pkg::sample_t                q_r [revq15_pkg::OUTQ_DEPTH];
  logic [revq15_pkg::OUTQ_AW-1:0]     wr_r;
  logic [revq15_pkg::OUTQ_AW-1:0]     rd_r;
  logic [revq15_pkg::OUTQ_AW:0]       cnt_r;
  logic [revq15_pkg::OUTQ_AW:0]       cnt_nxt;
  logic                               pop;

  function automatic logic [revq15_pkg::OUTQ_AW-1:0] ptr_inc(
    input logic [revq15_pkg::OUTQ_AW-1:0] p
  );
    if (p == revq15_pkg::OUTQ_AW'(revq15_pkg::OUTQ_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign out_valid  = (cnt_r != '0);
  assign out_sample = q_r[rd_r];
  assign pop        = out_valid && !out_stall;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push.vld && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.vld && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.vld) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (pop) begin
        rd_r <= ptr_inc(rd_r);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push.vld) begin
      q_r[wr_r] <= push.data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/revq15_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

// port-level checks on the reverb block
module revq15_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_sample
);

  logic [3:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_sample), "stalled result changed")
  `ASSERT_CLK(a_no_extra, clk, rst_n, out_valid |-> pend_r != 4'd0, "result with no request outstanding")
  `ASSERT_CLK(a_credit, clk, rst_n, pend_r >= 4'(revq15_pkg::OUTQ_DEPTH) |-> in_stall, "request taken with queue full")
  `ASSERT_CLK_ALWAYS(a_reset, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind comb_allpass_reverb_q15 revq15_chk u_revq15_chk (.*);

`default_nettype wire

// ===== tb/sv/reverb_checker.sv =====
module reverb_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [15:0]            in_sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [15:0]            out_sample,
  input  logic                          cfg_we,
  input  logic [revq15_pkg::CFG_AW-1:0] cfg_index,
  input  logic [revq15_pkg::CFG_DW-1:0] cfg_data,
  output int                            mismatches,
  output int                            awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_WORDS = 4096;
  localparam logic [11:0] DIFFUSE_ONE = 12'd240;
  localparam logic [11:0] DIFFUSE_TWO = 12'd590;

  // mirror of the delay lines, shared write position and registers
  logic signed [15:0] comb_words [4][LINE_WORDS];
  logic signed [15:0] diffuse_words [2][LINE_WORDS];
  logic [11:0]        head;
  logic               reverb_on;
  logic signed [15:0] fb_gain;
  logic [14:0]        wet_weight;
  logic [11:0]        comb_delay [4];

  logic signed [15:0] expected_samples [$];
  logic signed [15:0] want;
  int                 errors;

  // one sample through four combs, two diffusers and the dry/wet mix, or unchanged with reverb off
  function automatic logic signed [15:0] reverb_predict(input logic signed [15:0] x);
    logic signed [15:0] y;
    logic signed [15:0] sum;
    logic signed [15:0] wet;
    logic signed [15:0] old;
    logic [11:0]        tap;
    int                 prod;
    int                 mixed;
    if (!reverb_on) return x;
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      // read before write, so a zero delay sees the word from a full lap ago
      tap = head - comb_delay[k];
      y = comb_words[k][tap] + x;
      prod = fb_gain * y;
      comb_words[k][head] = 16'(x + (prod >>> 15));
      sum = sum + y;
    end
    wet = sum >>> 2;
    for (int k = 0; k < 2; k++) begin
      tap = head - ((k == 0) ? DIFFUSE_ONE : DIFFUSE_TWO);
      old = diffuse_words[k][tap];
      diffuse_words[k][head] = wet;
      wet = old - wet;
    end
    mixed = (int'(wet_weight) * int'(wet) + (32768 - int'(wet_weight)) * int'(x)) >>> 15;
    head = head + 12'd1;
    return 16'(mixed);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++)
        for (int a = 0; a < LINE_WORDS; a++) comb_words[k][a] = '0;
      for (int k = 0; k < 2; k++)
        for (int a = 0; a < LINE_WORDS; a++) diffuse_words[k][a] = '0;
      head = '0;
      reverb_on = 1'b0;
      fb_gain = 16'sd27525;
      wet_weight = 15'd16384;
      comb_delay[0] = 12'd1425;
      comb_delay[1] = 12'd1780;
      comb_delay[2] = 12'd1972;
      comb_delay[3] = 12'd2097;
      expected_samples.delete();
      errors = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (revq15_pkg::cfg_reg_t'(cfg_index))
          revq15_pkg::REG_ENABLE:  reverb_on = cfg_data[0];
          revq15_pkg::REG_GAIN:    fb_gain = cfg_data;
          revq15_pkg::REG_WET:     wet_weight = cfg_data[14:0];
          revq15_pkg::REG_DELAY_A: comb_delay[0] = cfg_data[11:0];
          revq15_pkg::REG_DELAY_B: comb_delay[1] = cfg_data[11:0];
          revq15_pkg::REG_DELAY_C: comb_delay[2] = cfg_data[11:0];
          revq15_pkg::REG_DELAY_D: comb_delay[3] = cfg_data[11:0];
          default: ;
        endcase
      end

      // accepted input request
      if (in_valid && !in_stall) expected_samples.push_back(reverb_predict(in_sample));

      // accepted result against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          if (errors < 10) $display("unexpected result: out_sample %0d at %0t",
                                    out_sample, $realtime);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            if (errors < 10) $display("out_sample mismatch: expected %0d, got %0d at %0t",
                                      want, out_sample, $realtime);
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    awaiting <= expected_samples.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [15:0]             in_sample = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [15:0]             out_sample;
  logic                           cfg_we = 1'b0;
  logic [revq15_pkg::CFG_AW-1:0]  cfg_index = '0;
  logic [revq15_pkg::CFG_DW-1:0]  cfg_data = '0;
  int                             mismatches;
  int                             awaiting;
  int                             burst_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  comb_allpass_reverb_q15 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  reverb_checker reverb_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // one sample request, sent in bursts with random gaps between them
  task automatic send_sample(input logic signed [15:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic put_reg(input revq15_pkg::cfg_reg_t idx,
                         input logic [revq15_pkg::CFG_DW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // full register set, written only once the block has drained
  task automatic program_reverb(input logic on, input logic signed [15:0] gain,
                                input logic [14:0] wet, input logic [11:0] da,
                                input logic [11:0] db, input logic [11:0] dc,
                                input logic [11:0] dd);
    wait_idle();
    put_reg(revq15_pkg::REG_ENABLE, revq15_pkg::CFG_DW'(on));
    put_reg(revq15_pkg::REG_GAIN, gain);
    put_reg(revq15_pkg::REG_WET, revq15_pkg::CFG_DW'(wet));
    put_reg(revq15_pkg::REG_DELAY_A, revq15_pkg::CFG_DW'(da));
    put_reg(revq15_pkg::REG_DELAY_B, revq15_pkg::CFG_DW'(db));
    put_reg(revq15_pkg::REG_DELAY_C, revq15_pkg::CFG_DW'(dc));
    put_reg(revq15_pkg::REG_DELAY_D, revq15_pkg::CFG_DW'(dd));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short delays so the comb feedback builds up within a phase
  function automatic logic [11:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom);
      default: return 12'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_wet();
    case ($urandom_range(0, 3))
      0: return 15'd0;
      1: return 15'd32767;
      default: return 15'($urandom);
    endcase
  endfunction

  // receiver: stall pattern in segments, plus a long hold-off now and then
  initial begin
    int taken;
    int next_hold;
    int hold_left;
    int seg_left;
    int mode;
    taken = 0;
    next_hold = 120;
    hold_left = 0;
    seg_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (taken >= next_hold) begin
        hold_left = 299;
        next_hold = taken + 400;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 64);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic signed [15:0] corner_values [7];
    corner_values = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1, 16'sh5555, 16'shaaaa};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // pass-through with register defaults after reset
    foreach (corner_values[i]) send_sample(corner_values[i]);

    // reverb on, default gain, mix and delays
    wait_idle();
    put_reg(revq15_pkg::REG_ENABLE, revq15_pkg::CFG_DW'(1));
    cfg_we <= 1'b0;
    foreach (corner_values[i]) send_sample(corner_values[i]);

    // full-scale gain and wet mix, zero and longest delays, wrapping sums
    program_reverb(1'b1, 16'sh7fff, 15'd32767, 12'd0, 12'd1, 12'd4095, 12'd2);
    repeat (3) send_sample(16'sh7fff);
    repeat (3) send_sample(16'sh8000);

    // most negative gain, dry only
    program_reverb(1'b1, 16'sh8000, 15'd0, 12'd4095, 12'd0, 12'd3, 12'd0);
    for (int i = 0; i < 5; i++) send_sample(corner_values[i]);

    // random settings, one of them with reverb off so the lines must hold
    for (int p = 0; p < 6; p++) begin
      program_reverb(p != 3, pick_gain(), pick_wet(), pick_delay(), pick_delay(),
                     pick_delay(), pick_delay());
      repeat (110) send_sample(pick_sample());
    end

    // zero and longest delays together with random gain and mix
    program_reverb(1'b1, 16'($urandom), 15'($urandom), 12'd0, 12'd4095,
                   12'($urandom_range(1, 64)), 12'($urandom));
    repeat (40) send_sample(pick_sample());

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
